// File: design/saa_pkg.sv
// ----------------------------------------------------------------------------
// saa_pkg
// Shared types, codes and defaults for the aligned stack allocator.
// ----------------------------------------------------------------------------
package saa_pkg;

    localparam int DEF_MAX_STACK_BYTES = 4096;
    localparam int DEF_ADDR_BITS       = 32;
    localparam int DEF_MAX_ALIGN_LOG2  = 7;

    localparam int ADDR_W   = 32;
    localparam int OFF_W    = 13;
    localparam int CMD_W    = 3;
    localparam int ALOG_W   = 3;
    localparam int STATUS_W = 2;
    localparam int PAD_W    = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [OFF_W-1:0] STACK_SIZE_RESET = 13'd4096;

    localparam logic [CMD_W-1:0] CMD_ALLOC_ALIGNED   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ALLOC_UNALIGNED = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FREE_ALIGNED    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FREE_UNALIGNED  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FREE_TO_MARKER  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAR           = 3'd5;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_SPACE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STACK_SIZE   = 1'd1;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [OFF_W-1:0]  alloc_bytes;
        logic [ALOG_W-1:0] align_log2;
        logic [ADDR_W-1:0] address;
        logic [OFF_W-1:0]  marker_value;
    } saa_in_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   result_address;
        logic [OFF_W-1:0]    top_offset;
        logic [STATUS_W-1:0] status;
    } saa_out_t;

endpackage

// File: design/stack_allocator_aligned_unit.sv
// ----------------------------------------------------------------------------
// stack_allocator_aligned_unit
// Stack allocator with aligned allocate/free, padding bytes kept in a RAM.
// ----------------------------------------------------------------------------
//   channel  ports                          direction  width
//   request  s_valid s_ready s_payload      in         64
//   result   m_valid m_ready m_payload      out        47
//   config   cfg_we cfg_index cfg_wdata     in         34
//
// For each command the accept edge issues the padding RAM read; the update
// edge then updates the marker, writes the RAM and loads the result.
// The result register holds a finished transfer while the next command is
// accepted; the update stage stalls only while it is full and m_ready is low.
// Reset clears the marker and base address and sets the size to 4096 bytes;
// the padding RAM has no reset.
// ----------------------------------------------------------------------------
module stack_allocator_aligned_unit #(
    parameter int MAX_STACK_BYTES = saa_pkg::DEF_MAX_STACK_BYTES,
    parameter int ADDR_BITS       = saa_pkg::DEF_ADDR_BITS,
    parameter int MAX_ALIGN_LOG2  = saa_pkg::DEF_MAX_ALIGN_LOG2
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  saa_pkg::saa_in_t                s_payload,
    output logic                            m_valid,
    input  logic                            m_ready,
    output saa_pkg::saa_out_t               m_payload,
    input  logic                            cfg_we,
    input  logic [saa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [saa_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import saa_pkg::*;

    localparam int MW   = $clog2(MAX_STACK_BYTES + 1);
    localparam int PW   = $clog2(MAX_STACK_BYTES);
    localparam int AW   = ADDR_BITS;
    localparam int AL_W = MAX_ALIGN_LOG2 + 1;
    localparam int CW   = ((MW > OFF_W) ? MW : OFF_W) + 2;
    localparam int EW   = (AW > CW) ? AW : CW;

    localparam logic [ALOG_W-1:0] ALOG_MAX = ALOG_W'(MAX_ALIGN_LOG2);
    localparam logic [CW-1:0]     LIM_MAX  = CW'(MAX_STACK_BYTES);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic              state_reg, state_next;
    logic [ADDR_W-1:0] base_addr_reg;
    logic [OFF_W-1:0]  stack_size_reg;
    logic [MW-1:0]     marker_reg, marker_next;

    logic [CMD_W-1:0]  cmd_reg;
    logic [OFF_W-1:0]  req_size_reg;
    logic [ALOG_W-1:0] alog_reg;
    logic [OFF_W-1:0]  mval_reg;
    logic [AW-1:0]     off_reg;

    logic              m_valid_reg;
    saa_out_t          out_reg, out_next;

    logic              accept, done;
    logic [AW-1:0]     base_a, off_in;
    logic [PW-1:0]     rd_addr;
    logic [PAD_W-1:0]  pad_rd;
    logic              pad_we;
    logic [PW-1:0]     pad_waddr;
    logic [PAD_W-1:0]  pad_wdata;

    logic [CW-1:0]     lim, mark_c, size_c, need;
    logic [ALOG_W-1:0] alog_eff;
    logic [AL_W-1:0]   align, adj;
    logic [AW-1:0]     raw_addr;
    logic [EW-1:0]     off_e, lim_e, pad_e, raw_off;
    logic [CW-1:0]     slot;

    assign s_ready   = (state_reg == S_IDLE);
    assign accept    = s_valid && s_ready;
    assign done      = (state_reg == S_EXEC) && (!m_valid_reg || m_ready);
    assign m_valid   = m_valid_reg;
    assign m_payload = out_reg;

    assign base_a  = AW'(base_addr_reg);
    assign off_in  = AW'(s_payload.address) - base_a;
    assign rd_addr = PW'(off_in - AW'(1));

    saa_pad_store #(
        .DEPTH (MAX_STACK_BYTES),
        .IDX_W (PW)
    ) u_pad_store (
        .aclk    (aclk),
        .wr_en   (pad_we),
        .wr_addr (pad_waddr),
        .wr_data (pad_wdata),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (pad_rd)
    );

    always_comb begin
        lim      = (CW'(stack_size_reg) > LIM_MAX) ? LIM_MAX : CW'(stack_size_reg);
        mark_c   = CW'(marker_reg);
        size_c   = CW'(req_size_reg);
        alog_eff = (alog_reg > ALOG_MAX) ? ALOG_MAX : alog_reg;
        align    = AL_W'(1) << alog_eff;
        raw_addr = base_a + AW'(marker_reg);
        adj      = align - (AL_W'(raw_addr) & (align - AL_W'(1)));
        need     = mark_c + size_c;
        slot     = mark_c + CW'(adj) - CW'(1);
        off_e    = EW'(off_reg);
        lim_e    = EW'(lim);
        pad_e    = EW'(pad_rd);
        raw_off  = off_e - pad_e;

        marker_next = marker_reg;
        out_next.result_address = '0;
        out_next.status         = STATUS_OK;
        pad_we    = 1'b0;
        pad_waddr = PW'(slot);
        pad_wdata = PAD_W'(adj);

        unique case (cmd_reg)
            CMD_ALLOC_ALIGNED: begin
                if (need + CW'(align) > lim) begin
                    out_next.status = STATUS_NO_SPACE;
                end else begin
                    out_next.result_address = ADDR_W'(raw_addr + AW'(adj));
                    pad_we      = done;
                    marker_next = MW'(need + CW'(adj));
                end
            end
            CMD_ALLOC_UNALIGNED: begin
                if (need > lim) begin
                    out_next.status = STATUS_NO_SPACE;
                end else begin
                    out_next.result_address = ADDR_W'(raw_addr);
                    marker_next = MW'(need);
                end
            end
            CMD_FREE_ALIGNED: begin
                if (off_e == '0 || off_e > lim_e || pad_e > off_e || raw_off >= lim_e) begin
                    out_next.status = STATUS_RANGE;
                end else begin
                    marker_next = MW'(raw_off);
                end
            end
            CMD_FREE_UNALIGNED: begin
                if (off_e >= lim_e) begin
                    out_next.status = STATUS_RANGE;
                end else begin
                    marker_next = MW'(off_reg);
                end
            end
            CMD_FREE_TO_MARKER: begin
                if (CW'(mval_reg) > lim) begin
                    out_next.status = STATUS_RANGE;
                end else begin
                    marker_next = MW'(mval_reg);
                end
            end
            CMD_CLEAR: begin
                marker_next = '0;
            end
            default: begin
                marker_next = marker_reg;
            end
        endcase

        out_next.top_offset = OFF_W'(marker_next);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (done) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            marker_reg     <= '0;
            m_valid_reg    <= 1'b0;
            base_addr_reg  <= '0;
            stack_size_reg <= STACK_SIZE_RESET;
        end else begin
            state_reg <= state_next;
            if (done) begin
                marker_reg  <= marker_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_BASE_ADDRESS: base_addr_reg  <= ADDR_W'(cfg_wdata);
                    CFG_STACK_SIZE:   stack_size_reg <= OFF_W'(cfg_wdata);
                    default:          base_addr_reg  <= base_addr_reg;
                endcase
            end
        end
    end

    // hold the accepted command for the update stage and load the result register
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg      <= s_payload.command;
            req_size_reg <= s_payload.alloc_bytes;
            alog_reg     <= s_payload.align_log2;
            mval_reg     <= s_payload.marker_value;
            off_reg      <= off_in;
        end
        if (done) begin
            out_reg <= out_next;
        end
    end

    a_marker_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        marker_reg <= MW'(MAX_STACK_BYTES))
        else $error("stack marker beyond region");

    a_fail_keeps_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        (done && out_next.status != STATUS_OK) |=> marker_reg == $past(marker_reg))
        else $error("failed command moved the marker");

    a_pad_write_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        pad_we |-> (done && cmd_reg == CMD_ALLOC_ALIGNED && out_next.status == STATUS_OK))
        else $error("padding write outside aligned allocate");

    a_result_from_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == S_EXEC)
        else $error("result transfer without update stage");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("accept while a command is in flight");

endmodule

// File: design/saa_pad_store.sv
// ----------------------------------------------------------------------------
// saa_pad_store
// Padding byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module saa_pad_store #(
    parameter int DEPTH   = saa_pkg::DEF_MAX_STACK_BYTES,
    parameter int IDX_W   = $clog2(DEPTH)
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [IDX_W-1:0]         wr_addr,
    input  logic [saa_pkg::PAD_W-1:0] wr_data,
    input  logic                     rd_en,
    input  logic [IDX_W-1:0]         rd_addr,
    output logic [saa_pkg::PAD_W-1:0] rd_data
);
    import saa_pkg::*;

    logic [PAD_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the aligned stack allocator. A short directed pass
// walks the region edges, every command and the error codes; random
// allocate/free sequences follow under several base/size settings. Every
// result transfer is checked against a plan or the in-bench allocator model.
// ----------------------------------------------------------------------------
module tb_top;
    import saa_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;
    localparam int REGION_MAX = 4096;
    localparam int PAD_IDX_W  = $clog2(REGION_MAX);
    localparam int IDLE_PCT   = 26;

    typedef struct {
        saa_in_t  req;
        bit       typed;
        saa_out_t want;
    } plan_row_t;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        bit                aligned;
        logic [OFF_W-1:0]  mark;
    } block_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    saa_in_t               s_payload = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    saa_out_t              m_payload;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    stack_allocator_aligned_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    logic [ADDR_W-1:0] base_q   = '0;
    logic [OFF_W-1:0]  span_q   = STACK_SIZE_RESET;
    logic [OFF_W-1:0]  marker_q = '0;
    logic [PAD_W-1:0]  pad_mem [REGION_MAX];
    bit                pad_set [REGION_MAX];

    saa_out_t  pending_results [$];
    block_t    live_blocks [$];
    plan_row_t dir_plan [$];
    bit        calm   = 1'b0;
    int        errors = 0;

    function automatic int unsigned room();
        return (span_q > REGION_MAX) ? REGION_MAX : span_q;
    endfunction

    function automatic bit take_break();
        return !calm && ($urandom_range(0, 99) < IDLE_PCT);
    endfunction

    function automatic bit free_is_safe(logic [ADDR_W-1:0] addr);
        logic [ADDR_W-1:0] off;
        off = addr - base_q;
        return (off == 0) || (off > room()) || pad_set[PAD_IDX_W'(off - 1)];
    endfunction

    function automatic logic [OFF_W-1:0] draw_size(int unsigned lim);
        if ($urandom_range(0, 15) == 0)
            return OFF_W'($urandom);
        return OFF_W'($urandom_range(0, lim / 12 + 2));
    endfunction

    function automatic plan_row_t plan_row(logic [CMD_W-1:0] cmd, logic [OFF_W-1:0] size,
                                           logic [ALOG_W-1:0] alog, logic [ADDR_W-1:0] addr,
                                           logic [OFF_W-1:0] mval, bit typed,
                                           logic [ADDR_W-1:0] raddr, logic [OFF_W-1:0] top,
                                           logic [STATUS_W-1:0] st);
        plan_row_t r;
        r.req.command        = cmd;
        r.req.alloc_bytes    = size;
        r.req.align_log2     = alog;
        r.req.address        = addr;
        r.req.marker_value   = mval;
        r.typed              = typed;
        r.want.result_address = raddr;
        r.want.top_offset    = top;
        r.want.status        = st;
        return r;
    endfunction

    // Allocator model: update marker and padding bytes, return the result.
    task automatic apply_command(input saa_in_t req, output saa_out_t res);
        int unsigned          lim;
        int unsigned          align;
        int unsigned          adj;
        logic [ADDR_W-1:0]    off;
        logic [ADDR_W-1:0]    raw;
        logic [ADDR_W-1:0]    raw_off;
        logic [PAD_IDX_W-1:0] slot;
        lim = room();
        res = '0;
        res.status = STATUS_OK;
        case (req.command)
            CMD_ALLOC_ALIGNED: begin
                align = 1 << req.align_log2;
                if (marker_q + req.alloc_bytes + align > lim) begin
                    res.status = STATUS_NO_SPACE;
                end else begin
                    raw = base_q + marker_q;
                    adj = align - (raw & (align - 1));
                    res.result_address = raw + adj;
                    slot = PAD_IDX_W'(marker_q + adj - 1);
                    pad_mem[slot] = adj[PAD_W-1:0];
                    pad_set[slot] = 1'b1;
                    marker_q = OFF_W'(marker_q + req.alloc_bytes + adj);
                end
            end
            CMD_ALLOC_UNALIGNED: begin
                if (marker_q + req.alloc_bytes > lim) begin
                    res.status = STATUS_NO_SPACE;
                end else begin
                    res.result_address = base_q + marker_q;
                    marker_q = marker_q + req.alloc_bytes;
                end
            end
            CMD_FREE_ALIGNED: begin
                off = req.address - base_q;
                if (off == 0 || off > lim) begin
                    res.status = STATUS_RANGE;
                end else begin
                    raw_off = req.address - pad_mem[PAD_IDX_W'(off - 1)] - base_q;
                    if (raw_off >= lim)
                        res.status = STATUS_RANGE;
                    else
                        marker_q = raw_off[OFF_W-1:0];
                end
            end
            CMD_FREE_UNALIGNED: begin
                off = req.address - base_q;
                if (off >= lim)
                    res.status = STATUS_RANGE;
                else
                    marker_q = off[OFF_W-1:0];
            end
            CMD_FREE_TO_MARKER: begin
                if (req.marker_value > lim)
                    res.status = STATUS_RANGE;
                else
                    marker_q = req.marker_value;
            end
            CMD_CLEAR: marker_q = '0;
            default: ;
        endcase
        res.top_offset = marker_q;
    endtask

    task automatic push_cmd(input saa_in_t req, input bit typed, input saa_out_t want);
        saa_out_t         got;
        logic [OFF_W-1:0] mark0;
        bit               is_alloc;
        while (take_break()) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        mark0    = marker_q;
        is_alloc = (req.command == CMD_ALLOC_ALIGNED) || (req.command == CMD_ALLOC_UNALIGNED);
        apply_command(req, got);
        pending_results.push_back(typed ? want : got);
        if (is_alloc) begin
            if (got.status == STATUS_OK)
                live_blocks.push_back('{got.result_address,
                                        req.command == CMD_ALLOC_ALIGNED, mark0});
        end else begin
            if (got.status == STATUS_RANGE && live_blocks.size() != 0
                    && req.address == live_blocks[$].addr)
                live_blocks.pop_back();
            while (live_blocks.size() != 0 && live_blocks[$].mark >= marker_q)
                live_blocks.pop_back();
        end
    endtask

    function automatic saa_in_t next_request();
        saa_in_t     req;
        int unsigned pick;
        int unsigned lim;
        lim  = room();
        req  = saa_in_t'({$urandom, $urandom});
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            req.command     = CMD_ALLOC_ALIGNED;
            req.alloc_bytes = draw_size(lim);
        end else if (pick < 50) begin
            req.command     = CMD_ALLOC_UNALIGNED;
            req.alloc_bytes = draw_size(lim);
        end else if (pick < 70 && live_blocks.size() != 0) begin
            req.command = live_blocks[$].aligned ? CMD_FREE_ALIGNED : CMD_FREE_UNALIGNED;
            req.address = live_blocks[$].addr;
        end else if (pick < 77) begin
            req.command = CMD_FREE_TO_MARKER;
            if (live_blocks.size() != 0 && $urandom_range(0, 1))
                req.marker_value = live_blocks[$urandom_range(0, live_blocks.size() - 1)].mark;
            else
                req.marker_value = OFF_W'($urandom_range(0, lim + 2));
        end else if (pick < 80) begin
            req.command = CMD_CLEAR;
        end else begin
            req.command = CMD_W'($urandom_range(0, 7));
            if ($urandom_range(0, 1))
                req.address = base_q + $urandom_range(0, lim + 2);
        end
        // never touch a padding byte that was not written
        if (req.command == CMD_FREE_ALIGNED && !free_is_safe(req.address))
            req.command = CMD_FREE_UNALIGNED;
        return req;
    endfunction

    task automatic run_random(input int n);
        saa_in_t req;
        int      k;
        k = 0;
        while (k < n) begin
            req = next_request();
            push_cmd(req, 1'b0, '0);
            k++;
        end
    endtask

    task automatic write_cfg(input logic [ADDR_W-1:0] base, input logic [OFF_W-1:0] span);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_BASE_ADDRESS;
        cfg_wdata <= base;
        @(posedge aclk);
        cfg_index <= CFG_STACK_SIZE;
        cfg_wdata <= CFG_DATA_W'(span);
        @(posedge aclk);
        cfg_we <= 1'b0;
        base_q = base;
        span_q = span;
        live_blocks.delete();
    endtask

    always @(posedge aclk) begin
        saa_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected transfer, expected none, actual %p", $time, m_payload);
            end else begin
                want = pending_results.pop_front();
                if (m_payload.result_address !== want.result_address) begin
                    errors++;
                    $display("%0t: result_address expected %h, actual %h",
                             $time, want.result_address, m_payload.result_address);
                end
                if (m_payload.top_offset !== want.top_offset) begin
                    errors++;
                    $display("%0t: top_offset expected %0d, actual %0d",
                             $time, want.top_offset, m_payload.top_offset);
                end
                if (m_payload.status !== want.status) begin
                    errors++;
                    $display("%0t: status expected %0d, actual %0d",
                             $time, want.status, m_payload.status);
                end
            end
        end
        m_ready <= !take_break();
    end

    initial begin
        dir_plan.push_back(plan_row(CMD_ALLOC_UNALIGNED, 0, 0, 0, 0, 1, 0, 0, STATUS_OK));
        dir_plan.push_back(plan_row(CMD_ALLOC_ALIGNED, 0, 0, 32'hFFFF_FFFF, 13'h1FFF,
                                    1, 1, 1, STATUS_OK));
        dir_plan.push_back(plan_row(CMD_FREE_ALIGNED, 13'h1FFF, 7, 1, 0, 1, 0, 0, STATUS_OK));
        dir_plan.push_back(plan_row(CMD_ALLOC_ALIGNED, 13'h1FFF, 7, 0, 0,
                                    1, 0, 0, STATUS_NO_SPACE));
        dir_plan.push_back(plan_row(CMD_ALLOC_UNALIGNED, 4096, 0, 0, 0, 1, 0, 4096, STATUS_OK));
        dir_plan.push_back(plan_row(CMD_ALLOC_UNALIGNED, 0, 0, 0, 0, 1, 4096, 4096, STATUS_OK));
        dir_plan.push_back(plan_row(CMD_ALLOC_UNALIGNED, 1, 0, 0, 0,
                                    1, 0, 4096, STATUS_NO_SPACE));
        dir_plan.push_back(plan_row(CMD_FREE_TO_MARKER, 0, 0, 0, 4097, 1, 0, 4096, STATUS_RANGE));
        dir_plan.push_back(plan_row(CMD_FREE_TO_MARKER, 0, 0, 0, 13'h1FFF,
                                    1, 0, 4096, STATUS_RANGE));
        dir_plan.push_back(plan_row(CMD_FREE_UNALIGNED, 0, 0, 0, 0, 1, 0, 0, STATUS_OK));
        dir_plan.push_back(plan_row(CMD_FREE_UNALIGNED, 0, 0, 4096, 0, 1, 0, 0, STATUS_RANGE));
        dir_plan.push_back(plan_row(CMD_FREE_UNALIGNED, 0, 0, 32'hFFFF_FFFF, 0,
                                    1, 0, 0, STATUS_RANGE));
        dir_plan.push_back(plan_row(CMD_FREE_ALIGNED, 0, 0, 0, 0, 1, 0, 0, STATUS_RANGE));
        dir_plan.push_back(plan_row(CMD_FREE_ALIGNED, 0, 0, 4097, 0, 1, 0, 0, STATUS_RANGE));
        dir_plan.push_back(plan_row(CMD_FREE_ALIGNED, 0, 0, 32'hFFFF_FFFF, 0,
                                    1, 0, 0, STATUS_RANGE));
        dir_plan.push_back(plan_row(CMD_ALLOC_UNALIGNED, 5, 0, 0, 0, 1, 0, 5, STATUS_OK));
        dir_plan.push_back(plan_row(CMD_ALLOC_ALIGNED, 3, 7, 0, 0, 0, 0, 0, STATUS_OK));
        dir_plan.push_back(plan_row(CMD_FREE_ALIGNED, 0, 0, 128, 0, 0, 0, 0, STATUS_OK));
        dir_plan.push_back(plan_row(CMD_ALLOC_ALIGNED, 0, 2, 0, 0, 0, 0, 0, STATUS_OK));
        dir_plan.push_back(plan_row(CMD_SPARE_6, 0, 0, 0, 0, 1, 0, 8, STATUS_OK));
        dir_plan.push_back(plan_row(CMD_SPARE_7, 13'h1FFF, 7, 32'hFFFF_FFFF, 13'h1FFF,
                                    1, 0, 8, STATUS_OK));
        dir_plan.push_back(plan_row(CMD_FREE_TO_MARKER, 0, 0, 0, 4096, 1, 0, 4096, STATUS_OK));
        dir_plan.push_back(plan_row(CMD_ALLOC_ALIGNED, 0, 0, 0, 0, 1, 0, 4096, STATUS_NO_SPACE));
        dir_plan.push_back(plan_row(CMD_CLEAR, 13'h1FFF, 7, 32'hFFFF_FFFF, 13'h1FFF,
                                    1, 0, 0, STATUS_OK));
        dir_plan.push_back(plan_row(CMD_FREE_TO_MARKER, 0, 0, 0, 0, 1, 0, 0, STATUS_OK));

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_plan[i])
            push_cmd(dir_plan[i].req, dir_plan[i].typed, dir_plan[i].want);

        write_cfg(32'h0000_0000, 13'd4096);
        run_random(500);
        write_cfg(32'hFFFF_FF40, 13'd512);
        run_random(400);
        write_cfg($urandom, 13'h1FFF);
        calm = 1'b1;
        run_random(250);
        calm = 1'b0;
        run_random(150);
        write_cfg(32'hFFFF_FFFF, 13'd1);
        run_random(100);
        write_cfg($urandom, 13'd0);
        run_random(50);
        write_cfg(32'h0000_1003, OFF_W'($urandom_range(2, 4096)));
        run_random(400);

        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #(5_000_000);
        $display("FAIL");
        $finish;
    end

endmodule
